// ===== hw/rtl/circular_buffer_deque_unit_macros.svh =====
// assertion macros used by the deque control block
`ifndef CIRCULAR_BUFFER_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_BUFFER_DEQUE_UNIT_MACROS_SVH

// property that must hold at every edge out of reset
`define CBD_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cbd_pkg.sv =====
// types, constants and codes shared by the deque rtl
`timescale 1ns / 1ps

package cbd_pkg;

  // storage geometry
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // field widths on the ports
  localparam int CAP_W      = 11;
  localparam int VAL_W      = 32;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;
  localparam int OCNT_W     = 11;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (VAL_W + ST_W + OCNT_W + 2);

  // width used for capacity compares
  localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_MIN    = 2;

  // configuration port
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;
  localparam logic [CFG_AW-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 11'd1024;

  // reset positions of the indices
  localparam logic [IDX_W-1:0] FRONT_RESET = IDX_W'(1);
  localparam logic [IDX_W-1:0] REAR_RESET  = IDX_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // request to the entry store
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [IDX_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] wdata;
  } mem_cmd_t;

  // result fields known at accept time, read data follows in the next cycle
  typedef struct packed {
    logic             rd_sel;
    status_t          status;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } result_t;

endpackage

// ===== hw/rtl/cbd_ram.sv =====
// single-clock entry store, one write and one registered read port
`timescale 1ns / 1ps

module cbd_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/cbd_ctrl.sv =====
// index and count bookkeeping, op decode and store requests
`timescale 1ns / 1ps
`include "circular_buffer_deque_unit_macros.svh"

module cbd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cbd_pkg::CAP_W-1:0]  capacity,
  input  logic                       acc,
  input  cbd_pkg::op_t               op,
  input  logic [cbd_pkg::VAL_W-1:0]  push_value,
  output cbd_pkg::mem_cmd_t          mem_cmd,
  output cbd_pkg::result_t           result
);

  localparam int IDX_W = cbd_pkg::IDX_W;
  localparam int CNT_W = cbd_pkg::CNT_W;
  localparam int CMP_W = cbd_pkg::CMP_W;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [CMP_W-1:0] cap_in, cap_eff, cnt_ext, front_ext, rear_ext;
  logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic             full, empty;
  logic             wr_req, rd_req;

  // clamp capacity to the usable range
  always_comb begin
    cap_in = CMP_W'(capacity);
    if (cap_in < CMP_W'(cbd_pkg::CAP_MIN)) begin
      cap_eff = CMP_W'(cbd_pkg::CAP_MIN);
    end else if (cap_in > CMP_W'(cbd_pkg::DEPTH)) begin
      cap_eff = CMP_W'(cbd_pkg::DEPTH);
    end else begin
      cap_eff = cap_in;
    end
  end

  // wrapped neighbors of both indices
  always_comb begin
    cnt_ext   = CMP_W'(count_r);
    front_ext = CMP_W'(front_r);
    rear_ext  = CMP_W'(rear_r);
    front_inc = ((front_ext + CMP_W'(1)) < cap_eff) ? IDX_W'(front_ext + CMP_W'(1)) : '0;
    rear_inc  = ((rear_ext + CMP_W'(1)) < cap_eff) ? IDX_W'(rear_ext + CMP_W'(1)) : '0;
    front_dec = (front_r == '0) ? IDX_W'(cap_eff - CMP_W'(1)) : front_r - IDX_W'(1);
    rear_dec  = (rear_r == '0) ? IDX_W'(cap_eff - CMP_W'(1)) : rear_r - IDX_W'(1);
    full      = (cnt_ext >= cap_eff);
    empty     = (count_r == '0);
  end

  // op decode
  always_comb begin
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    count_nxt     = count_r;
    wr_req        = 1'b0;
    rd_req        = 1'b0;
    mem_cmd.addr  = front_r;
    mem_cmd.wdata = push_value[cbd_pkg::DATA_WIDTH-1:0];
    result.rd_sel = 1'b0;
    result.status = cbd_pkg::ST_DONE;
    case (op)
      cbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          result.status = cbd_pkg::ST_FULL;
        end else begin
          front_nxt    = front_dec;
          mem_cmd.addr = front_dec;
          wr_req       = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      cbd_pkg::OP_PUSH_REAR: begin
        if (full) begin
          result.status = cbd_pkg::ST_FULL;
        end else begin
          rear_nxt     = rear_inc;
          mem_cmd.addr = rear_inc;
          wr_req       = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      cbd_pkg::OP_POP_FRONT, cbd_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          result.status = cbd_pkg::ST_EMPTY;
        end else begin
          mem_cmd.addr  = front_r;
          rd_req        = 1'b1;
          result.rd_sel = 1'b1;
          if (op == cbd_pkg::OP_POP_FRONT) begin
            front_nxt = front_inc;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      cbd_pkg::OP_POP_REAR, cbd_pkg::OP_PEEK_REAR: begin
        if (empty) begin
          result.status = cbd_pkg::ST_EMPTY;
        end else begin
          mem_cmd.addr  = rear_r;
          rd_req        = 1'b1;
          result.rd_sel = 1'b1;
          if (op == cbd_pkg::OP_POP_REAR) begin
            rear_nxt  = rear_dec;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      cbd_pkg::OP_CLEAR: begin
        front_nxt = cbd_pkg::FRONT_RESET;
        rear_nxt  = cbd_pkg::REAR_RESET;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    mem_cmd.wr_en   = acc & wr_req;
    mem_cmd.rd_en   = acc & rd_req;
    result.count    = count_nxt;
    result.is_empty = (count_nxt == '0);
    result.is_full  = (CMP_W'(count_nxt) >= cap_eff);
  end

  // index and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= cbd_pkg::FRONT_RESET;
      rear_r  <= cbd_pkg::REAR_RESET;
      count_r <= '0;
    end else if (acc) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
    end
  end

  // checks
  `CBD_ASSERT_NOW(a_count_bound, clk, rst_n, count_r <= CNT_W'(cbd_pkg::DEPTH), "count above depth")
  `CBD_ASSERT_NEXT(a_full_push_holds, clk, rst_n, acc && full && (op == cbd_pkg::OP_PUSH_FRONT || op == cbd_pkg::OP_PUSH_REAR), $stable(count_r) && $stable(front_r) && $stable(rear_r), "rejected push changed state")
  `CBD_ASSERT_NEXT(a_pop_decrements, clk, rst_n, acc && !empty && (op == cbd_pkg::OP_POP_FRONT || op == cbd_pkg::OP_POP_REAR), count_r == $past(count_r) - CNT_W'(1), "pop did not decrement count")
  `CBD_ASSERT_NEXT(a_clear_resets, clk, rst_n, acc && op == cbd_pkg::OP_CLEAR, count_r == '0 && front_r == cbd_pkg::FRONT_RESET && rear_r == cbd_pkg::REAR_RESET, "clear did not reset indices")
  `CBD_ASSERT_NOW(a_one_access, clk, rst_n, !(mem_cmd.wr_en && mem_cmd.rd_en), "read and write in one item")

endmodule

// ===== hw/rtl/circular_buffer_deque_unit.sv =====
// top level of the circular buffer deque: ports, config register, result stages
//
//   channel  dir  handshake          contents
//   in_      in   tvalid / tready    tuser: operation, tdata: push_value
//   out_     out  tvalid / tready    tdata: read_value, status, count, empty, full
//   cfg_     in   apb, pready high   capacity at byte address 0
//
// one item per cycle while out_tready stays high; an accepted item passes through the read
// stage, where the registered read of the entry store lands, and then the output register.
// reset (rst_n low, synchronous) returns indices and count to their start values and
// capacity to 1024; entries are not cleared, so a pop or peek can read unwritten cells.
// a stalled output holds one result in the output register and one in the read stage.
`timescale 1ns / 1ps

module circular_buffer_deque_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cbd_pkg::VAL_W-1:0]         in_tdata,   // [31:0] push_value
  input  logic [cbd_pkg::OP_W-1:0]          in_tuser,   // [2:0] operation
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] read_value, [33:32] status, [44:34] element_count,
  // [45] is_empty, [46] is_full, [47] zero
  output logic [cbd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cbd_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [cbd_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [cbd_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  logic [cbd_pkg::CAP_W-1:0]      capacity_r;
  logic                           acc;
  logic                           out_free;
  logic                           s1_move;
  logic                           s1_valid_r, s1_valid_nxt;
  cbd_pkg::result_t               s1_res_r;
  cbd_pkg::result_t               res;
  cbd_pkg::mem_cmd_t              mem_cmd;
  logic [cbd_pkg::DATA_WIDTH-1:0] rd_data;
  logic [cbd_pkg::VAL_W-1:0]      read_value;
  logic                           out_valid_r, out_valid_nxt;
  logic [cbd_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // configuration register
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= cbd_pkg::CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == cbd_pkg::REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[cbd_pkg::CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == cbd_pkg::REG_CAPACITY) ?
                      cbd_pkg::CFG_DW'(capacity_r) : '0;

  // handshake between the stages
  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign acc       = in_tvalid && in_tready;

  cbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .capacity   (capacity_r),
    .acc        (acc),
    .op         (cbd_pkg::op_t'(in_tuser)),
    .push_value (in_tdata),
    .mem_cmd    (mem_cmd),
    .result     (res)
  );

  cbd_ram #(
    .ADDR_W (cbd_pkg::IDX_W),
    .DATA_W (cbd_pkg::DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_cmd.wr_en),
    .wr_addr (mem_cmd.addr),
    .wr_data (mem_cmd.wdata),
    .rd_en   (mem_cmd.rd_en),
    .rd_addr (mem_cmd.addr),
    .rd_data (rd_data)
  );

  // read stage: result fields wait here for the store data
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
  end

  // output register
  assign read_value = s1_res_r.rd_sel ? cbd_pkg::VAL_W'(rd_data) : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{cbd_pkg::OUT_PAD_W{1'b0}}, s1_res_r.is_full, s1_res_r.is_empty,
                       cbd_pkg::OCNT_W'(s1_res_r.count), s1_res_r.status, read_value};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/tb_circular_buffer_deque_unit.sv =====
// testbench for the circular buffer deque: predicts every result and checks it under random stalls
`timescale 1ns / 1ps

module tb_circular_buffer_deque_unit;
  import cbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  // operation code outside the defined set, must be answered as a no-op
  localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

  // result transaction laid out as on out_tdata, lowest field last
  typedef struct packed {
    logic              pad;
    logic              full;
    logic              empty;
    logic [OCNT_W-1:0] count;
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  data;
  } deque_result_t;

  // shadow deque and the queue of results it expects
  class deque_scoreboard;
    logic [VAL_W-1:0] cells [DEPTH];
    bit               written [DEPTH];
    int               front_pos;
    int               rear_pos;
    int               fill;
    logic [CAP_W-1:0] cap_word;
    deque_result_t    expected_q [$];
    int               errors;

    function new();
      front_pos = 1;
      rear_pos  = 0;
      fill      = 0;
      cap_word  = CAP_RESET;
      errors    = 0;
    endfunction

    // capacity as the block uses it, clamped to 2..DEPTH
    function int eff_capacity();
      int c;
      c = int'(cap_word);
      if (c < CAP_MIN) c = CAP_MIN;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    function void set_capacity(logic [CFG_DW-1:0] w);
      cap_word = w[CAP_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // true when this pop or peek would read a cell never written since reset
    function bit reads_unwritten(logic [OP_W-1:0] op);
      if (fill == 0) return 1'b0;
      case (op)
        OP_POP_FRONT, OP_PEEK_FRONT: return !written[front_pos];
        OP_POP_REAR, OP_PEEK_REAR:   return !written[rear_pos];
        default:                     return 1'b0;
      endcase
    endfunction

    // apply one accepted input transaction and queue its result
    function void note_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] value);
      deque_result_t r;
      int            c;
      r = '0;
      c = eff_capacity();
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (fill >= c) begin
            r.status = ST_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            front_pos = (front_pos == 0) ? c - 1 : front_pos - 1;
            cells[front_pos]   = value;
            written[front_pos] = 1'b1;
            fill++;
          end else begin
            rear_pos = (rear_pos + 1 < c) ? rear_pos + 1 : 0;
            cells[rear_pos]   = value;
            written[rear_pos] = 1'b1;
            fill++;
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = cells[front_pos];
            if (op == OP_POP_FRONT) begin
              front_pos = (front_pos + 1 < c) ? front_pos + 1 : 0;
              fill--;
            end
          end
        end
        OP_POP_REAR, OP_PEEK_REAR: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = cells[rear_pos];
            if (op == OP_POP_REAR) begin
              rear_pos = (rear_pos == 0) ? c - 1 : rear_pos - 1;
              fill--;
            end
          end
        end
        OP_CLEAR: begin
          front_pos = 1;
          rear_pos  = 0;
          fill      = 0;
        end
        default: ;
      endcase
      r.count = OCNT_W'(fill);
      r.empty = (fill == 0);
      r.full  = (fill >= c);
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    // compare one accepted result transaction with the oldest expectation
    task check_result(deque_result_t got);
      deque_result_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing pending", got[VAL_W-1:0], '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.data !== want.data)     report("read_value", got.data, want.data);
      if (got.status !== want.status)
        report("status", VAL_W'(got.status), VAL_W'(want.status));
      if (got.count !== want.count)
        report("element_count", VAL_W'(got.count), VAL_W'(want.count));
      if (got.empty !== want.empty)
        report("is_empty", VAL_W'(got.empty), VAL_W'(want.empty));
      if (got.full !== want.full)
        report("is_full", VAL_W'(got.full), VAL_W'(want.full));
      if (got.pad !== want.pad)
        report("padding bit", VAL_W'(got.pad), VAL_W'(want.pad));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [VAL_W-1:0]      in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  deque_scoreboard sb = new();
  bit              idling = 1'b1;
  int              hold_left = 0;
  int              quiet_cycles = 0;

  circular_buffer_deque_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL circular_buffer_deque_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink with random stall bursts, started only while idling is set
  always @(negedge clk) begin
    if (hold_left == 0 && idling && $urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 4);
    out_tready <= (hold_left == 0);
    if (hold_left > 0) hold_left--;
  end

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // one apb access, setup then access phase
  task automatic apb_access(input bit wr, input logic [CFG_DW-1:0] w,
                            output logic [CFG_DW-1:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_CAPACITY;
    cfg_pwdata  <= w;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // capacity write once the block has drained, then read back
  task automatic write_capacity(input logic [CFG_DW-1:0] w);
    logic [CFG_DW-1:0] rd;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    apb_access(1'b1, w, rd);
    sb.set_capacity(w);
    // cfg_psel drops low between the two accesses
    @(negedge clk);
    apb_access(1'b0, '0, rd);
    if (rd !== {{(CFG_DW-CAP_W){1'b0}}, w[CAP_W-1:0]})
      sb.report("capacity readback", rd, {{(CFG_DW-CAP_W){1'b0}}, w[CAP_W-1:0]});
  endtask

  // random operation mix, pops and peeks never touch unwritten cells
  function automatic logic [OP_W-1:0] pick_op(int push_pct, bit clear_ok);
    logic [OP_W-1:0] op;
    int              r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    end else if (clear_ok && r < push_pct + 3) begin
      op = OP_CLEAR;
    end else if (r < push_pct + 5) begin
      op = OP_UNKNOWN;
    end else begin
      case ($urandom_range(0, 3))
        0:       op = OP_POP_FRONT;
        1:       op = OP_POP_REAR;
        2:       op = OP_PEEK_FRONT;
        default: op = OP_PEEK_REAR;
      endcase
    end
    if (sb.reads_unwritten(op)) op = OP_CLEAR;
    return op;
  endfunction

  // a run of random transactions; idling stops at quiet_from
  task automatic run_random(int n, int push_pct, bit clear_ok, int quiet_from);
    logic [VAL_W-1:0] value;
    idling = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      if (i == quiet_from) idling = 1'b0;
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      send_item(pick_op(push_pct, clear_ok), value);
    end
  endtask

  // stimulus
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty rejects, unknown code, wrap of the front index, clear
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_REAR, '1);
    send_item(OP_PEEK_FRONT, '0);
    send_item(OP_PEEK_REAR, '0);
    send_item(OP_UNKNOWN, '1);
    send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_REAR, 32'hA5A5_A5A5);
    send_item(OP_PUSH_REAR, 32'h5A5A_5A5A);
    send_item(OP_PEEK_FRONT, '0);
    send_item(OP_PEEK_REAR, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_REAR, '0);
    send_item(OP_UNKNOWN, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_REAR, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_REAR, 32'h1234_5678);
    send_item(OP_CLEAR, '1);
    send_item(OP_PEEK_REAR, '0);
    send_item(OP_PUSH_FRONT, 32'h8765_4321);
    send_item(OP_POP_REAR, '0);

    // smallest capacities, out-of-range values act as two
    write_capacity(32'd2);
    run_random(60, 50, 1'b1, -1);
    write_capacity(32'd0);
    run_random(50, 50, 1'b1, -1);
    write_capacity(32'hFFFF_F801);
    run_random(50, 50, 1'b1, -1);
    write_capacity(32'd3);
    run_random(80, 55, 1'b1, -1);

    // fill a mid capacity, shrink it with elements still stored, then write one above depth
    write_capacity(32'd17);
    run_random(120, 65, 1'b1, -1);
    write_capacity(32'd5);
    run_random(80, 40, 1'b0, -1);
    write_capacity(32'd1025);
    run_random(60, 50, 1'b1, -1);

    // random small capacities with noise in the upper write bits
    repeat (3) begin
      write_capacity(($urandom & ~32'h7FF) | $urandom_range(2, 40));
      run_random(70, 50, 1'b1, -1);
    end

    // full depth: push-heavy run that reaches full, no idling at the end
    write_capacity(32'd2047);
    run_random(1100, 96, 1'b0, 800);

    // drain and finish
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("PASS circular_buffer_deque_unit");
    end else begin
      $display("FAIL circular_buffer_deque_unit");
    end
    $finish;
  end

endmodule

// ===== circular_buffer_deque_unit.f =====
+incdir+hw/rtl
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_ram.sv
hw/rtl/cbd_ctrl.sv
hw/rtl/circular_buffer_deque_unit.sv
sim/tb_circular_buffer_deque_unit.sv
